// ----- hdl/sva_pkg.sv -----
package sva_pkg;

  // Field widths of the command and result words
  localparam int CMD_W   = 2;
  localparam int ENT_W   = 16;
  localparam int CHAN_W  = 3;
  localparam int MASK_W  = 8;
  localparam int VIDX_W  = 3;
  localparam int STAMP_W = 32;

  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [ENT_W-1:0]   entity_t;
  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [MASK_W-1:0]  mask_t;
  typedef logic [VIDX_W-1:0]  vidx_t;
  typedef logic [STAMP_W-1:0] stamp_t;

  // Command codes
  localparam cmd_t CMD_START    = 2'd0;
  localparam cmd_t CMD_STOP     = 2'd1;
  localparam cmd_t CMD_STOP_ALL = 2'd2;
  localparam cmd_t CMD_RELEASE  = 2'd3;

  // One command word as held in the input register
  typedef struct packed {
    cmd_t    command;
    entity_t entity;
    chan_t   ent_channel;
    mask_t   playing_mask;
  } cmd_word_t;

endpackage

// ----- hdl/sva_if.sv -----
// Command channel
interface sva_cmd_if import sva_pkg::*; ();
  logic    valid;
  logic    ready;
  cmd_t    command;
  entity_t entity;
  chan_t   ent_channel;
  mask_t   playing_mask;

  modport source (output valid, command, entity, ent_channel, playing_mask, input ready);
  modport sink   (input valid, command, entity, ent_channel, playing_mask, output ready);
endinterface

// Result channel
interface sva_res_if import sva_pkg::*; ();
  logic  valid;
  logic  ready;
  vidx_t chosen_voice;
  logic  chosen_valid;
  mask_t stopped_mask;

  modport source (output valid, chosen_voice, chosen_valid, stopped_mask, input ready);
  modport sink   (input valid, chosen_voice, chosen_valid, stopped_mask, output ready);
endinterface

// ----- hdl/sound_voice_allocator_core.sv -----
// Voice allocator with oldest-voice stealing. Takes one command word per clock while the
// result side is not stalled and returns one result word per command: the command is captured
// in an input register, the voice table is searched and updated from that register, and the
// result lands in an output register. Throughput is one command per cycle when not stalled,
// set by the update loop of the voice table, which is held in flip-flops and needs no clearing
// pass after reset. A start picks, in order: an active voice with the same entity and nonzero
// channel, the lowest voice whose player is idle, or the voice with the smallest start stamp
// (lowest index on a tie); the 32-bit stamp counter wraps and compares unsigned.
module sound_voice_allocator_core import sva_pkg::*; #(
  parameter int VOICES = 8
) (
  input logic       clk,
  input logic       rst,
  sva_cmd_if.sink   cmd,
  sva_res_if.source res
);

  localparam int IDX_W = $clog2(VOICES);
  // Only voices with a playing bit can all be busy at once
  localparam int OLD_N = (VOICES < MASK_W) ? VOICES : MASK_W;

  // Pipeline control
  logic      s1_valid;
  cmd_word_t s1_word;
  logic      out_valid;
  vidx_t     out_voice;
  logic      out_chosen;
  mask_t     out_stopped;
  logic      out_free;
  logic      s1_fire;
  logic      in_fire;

  // Voice table
  logic [VOICES-1:0] active;
  entity_t           ent_tab   [VOICES];
  chan_t             chan_tab  [VOICES];
  stamp_t            stamp_tab [VOICES];
  stamp_t            counter;

  // Decode
  logic [VOICES-1:0] playing;
  logic [VOICES-1:0] match;
  logic [OLD_N-1:0]  oldest_oh;
  logic [IDX_W-1:0]  match_idx;
  logic              match_any;
  logic [IDX_W-1:0]  idle_idx;
  logic              idle_any;
  logic [IDX_W-1:0]  oldest_idx;
  logic [IDX_W-1:0]  pick;
  logic [VOICES-1:0] pick_oh;
  logic [VOICES-1:0] stop_vec;
  logic [VOICES-1:0] active_next;
  stamp_t            counter_next;
  logic              is_start;

  assign out_free  = !out_valid || res.ready;
  assign s1_fire   = s1_valid && out_free;
  assign cmd.ready = !s1_valid || out_free;
  assign in_fire   = cmd.valid && cmd.ready;

  assign is_start     = (s1_word.command == CMD_START);
  assign counter_next = counter + stamp_t'(1);

  // Playing bits; voices past the mask read as idle
  for (genvar g = 0; g < VOICES; g++) begin : g_play
    if (g < MASK_W) begin : g_bit
      assign playing[g] = s1_word.playing_mask[g];
    end else begin : g_none
      assign playing[g] = 1'b0;
    end
    assign match[g] = active[g] && (ent_tab[g] == s1_word.entity)
                      && (chan_tab[g] == s1_word.ent_channel);
  end

  // Oldest voice: all pairwise compares in parallel, earlier index wins a tie
  always_comb begin
    for (int i = 0; i < OLD_N; i++) begin
      oldest_oh[i] = 1'b1;
      for (int j = 0; j < OLD_N; j++) begin
        if (j < i && !(stamp_tab[i] < stamp_tab[j])) oldest_oh[i] = 1'b0;
        if (j > i && (stamp_tab[j] < stamp_tab[i])) oldest_oh[i] = 1'b0;
      end
    end
  end

  // Priority encoders and voice choice
  always_comb begin
    match_idx  = '0;
    match_any  = 1'b0;
    idle_idx   = '0;
    idle_any   = 1'b0;
    oldest_idx = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (match[v]) begin
        match_idx = IDX_W'(v);
        match_any = 1'b1;
      end
      if (!playing[v]) begin
        idle_idx = IDX_W'(v);
        idle_any = 1'b1;
      end
    end
    for (int i = 0; i < OLD_N; i++) begin
      if (oldest_oh[i]) oldest_idx = oldest_idx | IDX_W'(i);
    end
    if (s1_word.ent_channel != '0 && match_any) begin
      pick = match_idx;
    end else if (idle_any) begin
      pick = idle_idx;
    end else begin
      pick = oldest_idx;
    end
    for (int v = 0; v < VOICES; v++) begin
      pick_oh[v] = (pick == IDX_W'(v));
    end
  end

  // Stopped voices and next active marks
  always_comb begin
    case (s1_word.command)
      CMD_START:    stop_vec = '0;
      CMD_STOP:     stop_vec = match;
      CMD_STOP_ALL: stop_vec = '1;
      CMD_RELEASE:  stop_vec = active & ~playing;
      default:      stop_vec = '0;
    endcase
    if (is_start) begin
      active_next = active | pick_oh;
    end else begin
      active_next = active & ~stop_vec;
    end
  end

  // Control and stamp state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      active    <= '0;
      counter   <= '0;
      for (int v = 0; v < VOICES; v++) begin
        stamp_tab[v] <= '0;
      end
    end else begin
      if (cmd.ready) s1_valid <= cmd.valid;
      if (out_free) out_valid <= s1_valid;
      if (s1_fire) begin
        active <= active_next;
        if (is_start) begin
          counter         <= counter_next;
          stamp_tab[pick] <= counter_next;
        end
      end
    end
  end

  // Payload registers and voice tags
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word.command      <= cmd.command;
      s1_word.entity       <= cmd.entity;
      s1_word.ent_channel  <= cmd.ent_channel;
      s1_word.playing_mask <= cmd.playing_mask;
    end
    if (s1_fire) begin
      out_voice   <= is_start ? VIDX_W'(pick) : '0;
      out_chosen  <= is_start;
      out_stopped <= MASK_W'(stop_vec);
      if (is_start) begin
        ent_tab[pick]  <= s1_word.entity;
        chan_tab[pick] <= s1_word.ent_channel;
      end
    end
  end

  assign res.valid        = out_valid;
  assign res.chosen_voice = out_voice;
  assign res.chosen_valid = out_chosen;
  assign res.stopped_mask = out_stopped;

  // Checks
  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    s1_fire && is_start |=> counter == stamp_t'($past(counter) + stamp_t'(1)))
    else $error("stamp counter did not advance on start");

  a_one_new_voice: assert property (@(posedge clk) disable iff (rst)
    $countones(active & ~$past(active)) <= 1)
    else $error("more than one voice activated at once");

  a_stop_all_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_word.command == CMD_STOP_ALL |=> active == '0)
    else $error("voices left active after stop all");

  a_start_no_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_chosen |-> out_stopped == '0)
    else $error("start word reports stopped voices");

endmodule

// ----- dv/sound_voice_allocator_monitor.sv -----
`timescale 1ns / 100ps

// Watches both channels of the voice allocator, keeps its own copy of the voice
// table and checks every result word against the oldest prediction.
module sound_voice_allocator_monitor import sva_pkg::*; #(
  parameter int VOICES = 8
) (
  input  logic    clk,
  input  logic    rst,
  // command channel
  input  logic    cmd_valid,
  input  logic    cmd_ready,
  input  cmd_t    command,
  input  entity_t entity,
  input  chan_t   ent_channel,
  input  mask_t   playing_mask,
  // result channel
  input  logic    res_valid,
  input  logic    res_ready,
  input  vidx_t   chosen_voice,
  input  logic    chosen_valid,
  input  mask_t   stopped_mask,
  // status for the top
  output int      errors,
  output int      outstanding
);

  typedef struct packed {
    vidx_t voice;
    logic  voice_ok;
    mask_t stopped;
  } voice_result_t;

  // mirrored voice table
  logic    tbl_active [VOICES];
  entity_t tbl_entity [VOICES];
  chan_t   tbl_chan   [VOICES];
  stamp_t  tbl_stamp  [VOICES];
  stamp_t  stamp_ctr;

  voice_result_t voice_result_q[$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(string what);
    errors = errors + 1;
    if (errors <= 200) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Predict one command word and update the mirrored table
  function automatic voice_result_t apply_voice_command(cmd_t c, entity_t e, chan_t ch,
                                                        mask_t m);
    voice_result_t r;
    int            pick;
    int            oldest;
    bit            found;
    r      = '0;
    pick   = 0;
    oldest = 0;
    found  = 1'b0;
    case (c)
      CMD_START: begin
        // reuse of a live voice on the same nonzero channel
        if (ch != '0) begin
          for (int v = 0; v < VOICES; v++) begin
            if (!found && tbl_active[v] && tbl_entity[v] == e && tbl_chan[v] == ch) begin
              pick  = v;
              found = 1'b1;
            end
          end
        end
        // first idle player, else the oldest stamp
        if (!found) begin
          for (int v = 0; v < VOICES; v++) begin
            if (!found) begin
              if (v >= MASK_W || !m[v]) begin
                pick  = v;
                found = 1'b1;
              end else if (tbl_stamp[v] < tbl_stamp[oldest]) begin
                oldest = v;
              end
            end
          end
          if (!found) pick = oldest;
        end
        stamp_ctr        = stamp_ctr + 1'b1;
        tbl_active[pick] = 1'b1;
        tbl_entity[pick] = e;
        tbl_chan[pick]   = ch;
        tbl_stamp[pick]  = stamp_ctr;
        r.voice          = vidx_t'(pick);
        r.voice_ok       = 1'b1;
      end
      CMD_STOP: begin
        for (int v = 0; v < VOICES; v++) begin
          if (tbl_active[v] && tbl_entity[v] == e && tbl_chan[v] == ch) begin
            tbl_active[v] = 1'b0;
            if (v < MASK_W) r.stopped[v] = 1'b1;
          end
        end
      end
      CMD_STOP_ALL: begin
        for (int v = 0; v < VOICES; v++) begin
          tbl_active[v] = 1'b0;
          if (v < MASK_W) r.stopped[v] = 1'b1;
        end
      end
      default: begin
        // release: live voices whose player has finished
        for (int v = 0; v < VOICES; v++) begin
          if (tbl_active[v] && (v >= MASK_W || !m[v])) begin
            tbl_active[v] = 1'b0;
            if (v < MASK_W) r.stopped[v] = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Sample both channels at the clock edge
  always @(posedge clk) begin
    voice_result_t want;
    if (rst) begin
      for (int v = 0; v < VOICES; v++) begin
        tbl_active[v] = 1'b0;
        tbl_entity[v] = '0;
        tbl_chan[v]   = '0;
        tbl_stamp[v]  = '0;
      end
      stamp_ctr = '0;
      voice_result_q.delete();
    end else begin
      if (res_valid === 1'b1 && res_ready === 1'b1) begin
        if (voice_result_q.size() == 0) begin
          report_mismatch("result word with no command waiting");
        end else begin
          want = voice_result_q.pop_front();
          if (chosen_voice !== want.voice)
            report_mismatch($sformatf("chosen_voice got %0d want %0d", chosen_voice,
                                      want.voice));
          if (chosen_valid !== want.voice_ok)
            report_mismatch($sformatf("chosen_valid got %b want %b", chosen_valid,
                                      want.voice_ok));
          if (stopped_mask !== want.stopped)
            report_mismatch($sformatf("stopped_mask got %h want %h", stopped_mask,
                                      want.stopped));
        end
      end
      if (cmd_valid === 1'b1 && cmd_ready === 1'b1)
        voice_result_q.push_back(apply_voice_command(command, entity, ent_channel,
                                                     playing_mask));
    end
    outstanding = voice_result_q.size();
  end

endmodule

// ----- dv/sound_voice_allocator_core_tb.sv -----
`timescale 1ns / 100ps

module sound_voice_allocator_core_tb import sva_pkg::*; ();

  logic clk;
  logic rst;
  int   errors;
  int   outstanding;
  int   send_idle_pct;
  int   recv_stall_pct;

  sva_cmd_if cmd_if ();
  sva_res_if res_if ();

  sound_voice_allocator_core #(.VOICES(8)) u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  sound_voice_allocator_monitor #(.VOICES(8)) u_monitor (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_if.valid),
    .cmd_ready    (cmd_if.ready),
    .command      (cmd_if.command),
    .entity       (cmd_if.entity),
    .ent_channel  (cmd_if.ent_channel),
    .playing_mask (cmd_if.playing_mask),
    .res_valid    (res_if.valid),
    .res_ready    (res_if.ready),
    .chosen_voice (res_if.chosen_voice),
    .chosen_valid (res_if.chosen_valid),
    .stopped_mask (res_if.stopped_mask),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one command word, with random idle cycles ahead of it
  task automatic send_word(cmd_t c, entity_t e, chan_t ch, mask_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.command      <= c;
    cmd_if.entity       <= e;
    cmd_if.ent_channel  <= ch;
    cmd_if.playing_mask <= m;
    @(posedge clk);
    while (cmd_if.ready !== 1'b1) @(posedge clk);
  endtask

  // Hold the sender until every predicted result has come back
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Random traffic: a small entity pool so that starts and stops hit live voices
  task automatic run_phase(int n, int s_idle, int r_stall);
    cmd_t    c;
    entity_t e;
    chan_t   ch;
    mask_t   m;
    int      pick;
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 55)      c = CMD_START;
      else if (pick < 75) c = CMD_STOP;
      else if (pick < 80) c = CMD_STOP_ALL;
      else                c = CMD_RELEASE;
      e  = ($urandom_range(99) < 80) ? entity_t'($urandom_range(3)) : entity_t'($urandom);
      ch = ($urandom_range(1) == 0) ? chan_t'($urandom_range(2)) : chan_t'($urandom);
      pick = $urandom_range(3);
      case (pick)
        0, 1: m = 8'hFF;
        2:    m = mask_t'($urandom);
        default: m = ~(mask_t'(1) << $urandom_range(7));
      endcase
      send_word(c, e, ch, m);
    end
    drain_results();
  endtask

  initial begin
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    rst                 = 1'b1;
    cmd_if.valid        = 1'b0;
    cmd_if.command      = CMD_START;
    cmd_if.entity       = '0;
    cmd_if.ent_channel  = '0;
    cmd_if.playing_mask = '0;
    res_if.ready        = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    send_word(CMD_START, 16'h0000, 3'd0, 8'h00);
    send_word(CMD_START, 16'hFFFF, 3'd7, 8'h01);
    // same entity and channel: reuse
    send_word(CMD_START, 16'hFFFF, 3'd7, 8'h00);
    // channel zero never reuses
    send_word(CMD_START, 16'h0000, 3'd0, 8'h03);
    for (int i = 0; i < 5; i++)
      send_word(CMD_START, entity_t'(16'h0010 + i), chan_t'(i + 1),
                mask_t'((9'h1 << (i + 3)) - 1));
    // all playing: steal the oldest
    send_word(CMD_START, 16'h5555, 3'd3, 8'hFF);
    send_word(CMD_START, 16'hAAAA, 3'd5, 8'hFF);
    send_word(CMD_STOP, 16'h5555, 3'd3, 8'h00);
    // stop on channel zero
    send_word(CMD_STOP, 16'h0000, 3'd0, 8'hFF);
    send_word(CMD_STOP, 16'h1234, 3'd1, 8'h00);
    send_word(CMD_RELEASE, 16'h0000, 3'd0, 8'hF0);
    send_word(CMD_RELEASE, 16'hFFFF, 3'd7, 8'h00);
    send_word(CMD_STOP_ALL, 16'h0000, 3'd0, 8'h00);
    // table cleared but stale stamps still pick the victim
    send_word(CMD_START, 16'hFFFF, 3'd7, 8'hFF);
    send_word(CMD_START, 16'hFFFF, 3'd7, 8'hFF);
    send_word(CMD_STOP_ALL, 16'hFFFF, 3'd7, 8'hFF);
    send_word(CMD_RELEASE, 16'hFFFF, 3'd7, 8'hFF);
    drain_results();

    // Random words across the idling phases
    run_phase(250, 0, 0);
    run_phase(250, 87, 0);
    run_phase(250, 0, 87);
    run_phase(250, 18, 18);

    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("sound_voice_allocator_core_tb passed");
    end else begin
      $display("sound_voice_allocator_core_tb failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("sound_voice_allocator_core_tb failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sva_pkg.sv
hdl/sva_if.sv
hdl/sound_voice_allocator_core.sv
dv/sound_voice_allocator_monitor.sv
dv/sound_voice_allocator_core_tb.sv
